### rtl/core/pfl_pkg.sv
// Shared types and constants for the per-hart page free-list allocator.
// No dependencies; imported by the allocator top level.
package pfl_pkg;

   localparam int ADDR_W     = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
   localparam int HART_IN_W  = 3;

   typedef logic [1:0] status_type;
   typedef logic [1:0] csr_idx_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // response status codes
   localparam status_type ST_DONE     = 2'd0;
   localparam status_type ST_OOM      = 2'd1;
   localparam status_type ST_BAD_ADDR = 2'd2;

   // configuration register indexes
   localparam csr_idx_type CSR_REGION_BASE = 2'd0;
   localparam csr_idx_type CSR_LOWEST_FREE = 2'd1;
   localparam csr_idx_type CSR_TOP_ADDR    = 2'd2;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam addr_type REGION_BASE_RST = 32'h8000_0000;
   localparam addr_type LOWEST_FREE_RST = 32'h8000_0000;
   localparam addr_type TOP_ADDR_RST    = 32'h8800_0000;

endpackage

### rtl/core/pfl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pfl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/per_hart_page_free_list_allocator_top.sv
// Per-hart LIFO page free-list allocator with stealing from other harts' lists.
// Depends on pfl_pkg and pfl_ram (list head RAM and next-link RAM).
//
//  channel  | direction | handshake              | payload
//  req_     | in        | req_valid / req_stall  | req_op, req_hart, req_addr
//  rsp_     | out       | rsp_valid / rsp_stall  | rsp_status, rsp_page_addr, rsp_source_hart
//  csr_     | in        | csr_wr_en              | csr_index, csr_wr_data
//
// One transaction at a time. A rejected free or an out-of-memory allocate goes straight to
// the done state, a good free does a head read, then link and head write-back, an allocate
// does a head read, then a next-link read, then a head write-back.
// The result sits in an output register, so a new request is taken while it waits.
// Synchronous reset empties every list (per-hart valid bits); no clearing pass.
// req_stall is high while a transaction is in flight or its result is not yet queued.
module per_hart_page_free_list_allocator_top #(
   parameter int NUM_HARTS = 8,
   parameter int NUM_PAGES = 32768
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [2:0]                      req_hart,
   input  pfl_pkg::addr_type               req_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pfl_pkg::status_type             rsp_status,
   output pfl_pkg::addr_type               rsp_page_addr,
   output logic [2:0]                      rsp_source_hart,
   input  logic                            csr_wr_en,
   input  pfl_pkg::csr_idx_type            csr_index,
   input  pfl_pkg::addr_type               csr_wr_data
);
   import pfl_pkg::*;

   localparam int HW = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
   localparam int PW = $clog2(NUM_PAGES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HEAD = 2'd1;
   localparam logic [1:0] S_LINK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   function automatic logic [HW-1:0] hart_wrap(input logic [HART_IN_W-1:0] h);
      logic [HART_IN_W:0] v;
      v = {1'b0, h};
      for (int i = 0; i < 8; i++) begin
         if (32'(v) >= NUM_HARTS) begin
            v = v - (HART_IN_W+1)'(NUM_HARTS);
         end
      end
      return HW'(v);
   endfunction

   // configuration
   addr_type region_base_ff, lowest_free_ff, top_addr_ff;

   // control
   logic [1:0]           state_ff, state_in;
   logic [NUM_HARTS-1:0] head_valid_ff, head_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // transaction context
   logic          op_ff, op_in;
   logic [HW-1:0] hart_ff, hart_in;
   logic [HW-1:0] src_ff, src_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic [PW-1:0] page_ff, page_in;
   status_type    res_status_ff, res_status_in;
   addr_type      res_page_ff, res_page_in;
   logic [HW-1:0] res_src_ff, res_src_in;

   status_type    rsp_status_ff;
   addr_type      rsp_page_ff;
   logic [2:0]    rsp_src_ff;

   // RAM ports
   logic          head_wr_en, head_rd_en;
   logic [HW-1:0] head_wr_addr, head_rd_addr;
   logic [PW-1:0] head_wr_data, head_rd_data;
   logic          link_wr_en, link_rd_en;
   logic [PW-1:0] link_wr_addr, link_rd_addr;
   logic [PW:0]   link_wr_data, link_rd_data;

   // request decode
   logic          accept;
   logic [HW-1:0] h_req;
   logic [HW-1:0] first_hart;
   logic          any_valid;
   logic [HW-1:0] src_sel;
   addr_type      base_addr;
   addr_type      diff;
   logic          free_ok;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign h_req = hart_wrap(req_hart);

   // lowest-numbered non-empty list
   always_comb begin
      first_hart = '0;
      any_valid  = 1'b0;
      for (int i = NUM_HARTS - 1; i >= 0; i--) begin
         if (head_valid_ff[i]) begin
            first_hart = HW'(i);
            any_valid  = 1'b1;
         end
      end
   end

   assign src_sel   = head_valid_ff[h_req] ? h_req : first_hart;
   assign base_addr = {region_base_ff[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
   assign diff      = req_addr - base_addr;
   assign free_ok   = (req_addr[PAGE_SHIFT-1:0] == '0) && (req_addr >= lowest_free_ff) &&
                      (req_addr < top_addr_ff) && (req_addr >= base_addr) &&
                      ({1'b0, diff[ADDR_W-1:PAGE_SHIFT]} < (PFN_W+1)'(NUM_PAGES));

   always_comb begin
      state_in      = state_ff;
      head_valid_in = head_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      op_in         = op_ff;
      hart_in       = hart_ff;
      src_in        = src_ff;
      idx_in        = idx_ff;
      page_in       = page_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_src_in    = res_src_ff;
      head_wr_en    = 1'b0;
      head_wr_addr  = hart_ff;
      head_wr_data  = idx_ff;
      head_rd_en    = 1'b0;
      head_rd_addr  = (req_op == OP_FREE) ? h_req : src_sel;
      link_wr_en    = 1'b0;
      link_wr_addr  = idx_ff;
      link_wr_data  = {head_valid_ff[hart_ff], head_rd_data};
      link_rd_en    = 1'b0;
      link_rd_addr  = head_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               hart_in       = h_req;
               src_in        = src_sel;
               idx_in        = diff[PAGE_SHIFT +: PW];
               res_status_in = ST_DONE;
               res_page_in   = '0;
               res_src_in    = '0;
               if (req_op == OP_FREE) begin
                  if (free_ok) begin
                     head_rd_en = 1'b1;
                     state_in   = S_HEAD;
                  end else begin
                     res_status_in = ST_BAD_ADDR;
                     state_in      = S_DONE;
                  end
               end else begin
                  if (any_valid) begin
                     head_rd_en = 1'b1;
                     state_in   = S_HEAD;
                  end else begin
                     res_status_in = ST_OOM;
                     state_in      = S_DONE;
                  end
               end
            end
         end
         S_HEAD: begin
            if (op_ff == OP_FREE) begin
               // push: new page links to the old head, then becomes the head
               link_wr_en             = 1'b1;
               head_wr_en             = 1'b1;
               head_valid_in[hart_ff] = 1'b1;
               state_in               = S_DONE;
            end else begin
               link_rd_en = 1'b1;
               page_in    = head_rd_data;
               state_in   = S_LINK;
            end
         end
         S_LINK: begin
            head_wr_en            = 1'b1;
            head_wr_addr          = src_ff;
            head_wr_data          = link_rd_data[PW-1:0];
            head_valid_in[src_ff] = link_rd_data[PW];
            res_page_in           = {region_base_ff[ADDR_W-1:PAGE_SHIFT] + PFN_W'(page_ff),
                                     {PAGE_SHIFT{1'b0}}};
            res_src_in            = src_ff;
            state_in              = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         region_base_ff <= REGION_BASE_RST;
         lowest_free_ff <= LOWEST_FREE_RST;
         top_addr_ff    <= TOP_ADDR_RST;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REGION_BASE: region_base_ff <= csr_wr_data;
               CSR_LOWEST_FREE: lowest_free_ff <= csr_wr_data;
               CSR_TOP_ADDR:    top_addr_ff    <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      hart_ff       <= hart_in;
      src_ff        <= src_in;
      idx_ff        <= idx_in;
      page_ff       <= page_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_src_ff    <= res_src_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_status_ff <= res_status_ff;
         rsp_page_ff   <= res_page_ff;
         rsp_src_ff    <= 3'(res_src_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_page_addr   = rsp_page_ff;
   assign rsp_source_hart = rsp_src_ff;

   pfl_ram #(
      .WIDTH (PW),
      .DEPTH (NUM_HARTS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   // bit PW marks that the link points at a real page (not end of list)
   pfl_ram #(
      .WIDTH (PW + 1),
      .DEPTH (NUM_PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

endmodule
